// ===== sv/blm_pkg.sv =====
// Shared types, constants and level helper functions of the battery level monitor.
package blm_pkg;

    localparam int BLM_SAMPLE_BITS = 10;
    localparam int BLM_MAX_AVERAGE = 16;

    localparam int VBG_W    = 10;
    localparam int THR_W    = 16;
    localparam int MARGIN_W = 8;
    localparam int AVG_W    = 5;
    localparam int SETTLE_W = 3;
    localparam int LEVEL_W  = 3;
    localparam int VOLT_W   = 16;
    localparam int NEED_W   = 7;
    localparam int ITER_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [LEVEL_W-1:0] LEVEL_ZERO    = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE     = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_TWO     = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_THREE   = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_FOUR    = 3'd4;
    localparam logic [LEVEL_W-1:0] LEVEL_UNKNOWN = 3'd7;
    localparam logic [VOLT_W-1:0]  TOP_BOUND     = 16'hffff;

    localparam logic [CFG_IDX_W-1:0] REG_VBG_SCALE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_ZERO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_ONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_TWO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_THREE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_COUNT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_COUNT    = 3'd7;

    typedef struct packed {
        logic [VBG_W-1:0]    vbg_scale;
        logic [THR_W-1:0]    threshold_zero;
        logic [THR_W-1:0]    threshold_one;
        logic [THR_W-1:0]    threshold_two;
        logic [THR_W-1:0]    threshold_three;
        logic [MARGIN_W-1:0] hysteresis_margin;
        logic [AVG_W-1:0]    average_count;
        logic [SETTLE_W-1:0] settle_count;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_LEVEL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic mul;
        logic div_init;
        logic div_step;
        logic level;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic avg_complete;
        logic div_skip;
        logic div_last;
        logic out_full;
    } stat_t;

    function automatic logic [VOLT_W-1:0] bound_of(input cfg_t c, input logic [LEVEL_W-1:0] lev);
        logic [VOLT_W-1:0] b;
        case (lev)
            LEVEL_ZERO:  b = c.threshold_zero;
            LEVEL_ONE:   b = c.threshold_one;
            LEVEL_TWO:   b = c.threshold_two;
            LEVEL_THREE: b = c.threshold_three;
            default:     b = TOP_BOUND;
        endcase
        return b;
    endfunction

    function automatic logic [LEVEL_W-1:0] map_level(input cfg_t c, input logic [VOLT_W-1:0] v);
        logic [LEVEL_W-1:0] lev;
        if (v <= c.threshold_zero) begin
            lev = LEVEL_ZERO;
        end else if (v <= c.threshold_one) begin
            lev = LEVEL_ONE;
        end else if (v <= c.threshold_two) begin
            lev = LEVEL_TWO;
        end else if (v <= c.threshold_three) begin
            lev = LEVEL_THREE;
        end else begin
            lev = LEVEL_FOUR;
        end
        return lev;
    endfunction

endpackage

// ===== sv/battery_level_monitor_core.sv =====
// Top level of the battery level monitor: controller, datapath and configuration registers.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_stall   battery_sample, reference_sample
//   output    out_valid / out_stall measured_level, stable_level, voltage_mv, flags
//   config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// A beat that does not complete an average goes through acceptance and the output load.
// A beat that completes an average goes through acceptance, one multiply, one divide
// setup, 16 steps of the restoring divider, one leveling step and one output load. With a
// zero reference sum or a saturated quotient the divide steps are skipped.
// The result is visible in the cycle after the output load.
// Reset clears the accumulators, sets the levels to unknown and loads the register defaults.
// While the output register holds an untaken result, the next input beat is still accepted;
// stall on the output side only holds the final cycle of the following beat.
module battery_level_monitor_core
    import blm_pkg::*;
#(
    parameter int SAMPLE_BITS = BLM_SAMPLE_BITS,
    parameter int MAX_AVERAGE = BLM_MAX_AVERAGE
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] battery_sample,
    input  logic [SAMPLE_BITS-1:0] reference_sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [LEVEL_W-1:0]     measured_level,
    output logic [LEVEL_W-1:0]     stable_level,
    output logic [VOLT_W-1:0]      voltage_mv,
    output logic                   measurement_done,
    output logic                   level_changed,
    output logic                   power_off_request,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    blm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    blm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    blm_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_AVERAGE (MAX_AVERAGE)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .cmd               (cmd),
        .stat              (stat),
        .battery_sample    (battery_sample),
        .reference_sample  (reference_sample),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .measured_level    (measured_level),
        .stable_level      (stable_level),
        .voltage_mv        (voltage_mv),
        .measurement_done  (measurement_done),
        .level_changed     (level_changed),
        .power_off_request (power_off_request)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while a beat is in progress");

    a_poweroff_on_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && power_off_request) |->
            (level_changed && stable_level == LEVEL_ZERO))
        else $error("power-off request without a change to level zero");

    a_change_follows_measured: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && level_changed) |-> (stable_level == measured_level))
        else $error("stable level differs from measured level on a change");

    a_measured_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (measured_level <= LEVEL_FOUR || measured_level == LEVEL_UNKNOWN))
        else $error("measured level out of range");

endmodule

// ===== sv/blm_cfg.sv =====
// Configuration register file of the battery level monitor.
module blm_cfg
    import blm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vbg_scale         <= 10'd800;
            cfg_reg.threshold_zero    <= 16'd3400;
            cfg_reg.threshold_one     <= 16'd3500;
            cfg_reg.threshold_two     <= 16'd3700;
            cfg_reg.threshold_three   <= 16'd3850;
            cfg_reg.hysteresis_margin <= 8'd10;
            cfg_reg.average_count     <= 5'd10;
            cfg_reg.settle_count      <= 3'd5;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_VBG_SCALE:       cfg_reg.vbg_scale <= cfg_data[VBG_W-1:0];
                REG_THRESHOLD_ZERO:  cfg_reg.threshold_zero <= cfg_data[THR_W-1:0];
                REG_THRESHOLD_ONE:   cfg_reg.threshold_one <= cfg_data[THR_W-1:0];
                REG_THRESHOLD_TWO:   cfg_reg.threshold_two <= cfg_data[THR_W-1:0];
                REG_THRESHOLD_THREE: cfg_reg.threshold_three <= cfg_data[THR_W-1:0];
                REG_HYSTERESIS:      cfg_reg.hysteresis_margin <= cfg_data[MARGIN_W-1:0];
                REG_AVERAGE_COUNT:   cfg_reg.average_count <= cfg_data[AVG_W-1:0];
                REG_SETTLE_COUNT:    cfg_reg.settle_count <= cfg_data[SETTLE_W-1:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// ===== sv/blm_ctrl.sv =====
// Controller state machine that sequences accumulation, multiply, division, leveling and output.
module blm_ctrl
    import blm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  logic  out_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.avg_complete ? ST_MUL : ST_FINISH;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = stat.div_skip ? ST_LEVEL : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_LEVEL;
                end
            end
            ST_LEVEL:
            begin
                cmd.level  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!stat.out_full || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/blm_dp.sv =====
// Datapath: sample accumulation, voltage multiply and serial divide, levels and output register.
module blm_dp
    import blm_pkg::*;
#(
    parameter int SAMPLE_BITS = BLM_SAMPLE_BITS,
    parameter int MAX_AVERAGE = BLM_MAX_AVERAGE
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  cmd_t                   cmd,
    output stat_t                  stat,
    input  logic [SAMPLE_BITS-1:0] battery_sample,
    input  logic [SAMPLE_BITS-1:0] reference_sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [LEVEL_W-1:0]     measured_level,
    output logic [LEVEL_W-1:0]     stable_level,
    output logic [VOLT_W-1:0]      voltage_mv,
    output logic                   measurement_done,
    output logic                   level_changed,
    output logic                   power_off_request
);

    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_AVERAGE);
    localparam int PROD_W = SUM_W + VBG_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int HI_W   = NUM_W - VOLT_W;
    localparam int CNT_W  = $clog2(MAX_AVERAGE + 1);

    logic [SUM_W-1:0]    bsum_reg;
    logic [SUM_W-1:0]    rsum_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [SUM_W-1:0]    ref_reg;
    logic [SUM_W-1:0]    rem_reg;
    logic [VOLT_W-1:0]   quot_reg;
    logic [ITER_W-1:0]   iter_reg;
    logic [LEVEL_W-1:0]  level_now_reg;
    logic [LEVEL_W-1:0]  level_settled_reg;
    logic [SETTLE_W-1:0] settle_cnt_reg;
    logic [VOLT_W-1:0]   last_voltage_reg;
    logic                done_pend_reg;
    logic                out_valid_reg;
    logic [LEVEL_W-1:0]  out_measured_reg;
    logic [LEVEL_W-1:0]  out_stable_reg;
    logic [VOLT_W-1:0]   out_voltage_reg;
    logic                out_done_reg;
    logic                out_changed_reg;
    logic                out_poweroff_reg;

    logic [NEED_W-1:0]   need;
    logic [NEED_W-1:0]   count_inc;
    logic                complete;
    logic [SUM_W-1:0]    num_hi;
    logic                overflow;
    logic [SUM_W:0]      rem_shift;
    logic [SUM_W:0]      rem_diff;
    logic                fits;
    logic [SUM_W-1:0]    rem_next;
    logic [LEVEL_W-1:0]  level_map;
    logic [LEVEL_W-1:0]  level_new;
    logic [VOLT_W:0]     v_plus_margin;
    logic [VOLT_W:0]     bound_plus_margin;
    logic [SETTLE_W-1:0] settle_load;
    logic [SETTLE_W-1:0] settle_dec;
    logic                differ;
    logic                commit;

    always_comb
    begin
        if (cfg.average_count == '0)
        begin
            need = NEED_W'(1);
        end
        else if (NEED_W'(cfg.average_count) > NEED_W'(MAX_AVERAGE))
        begin
            need = NEED_W'(MAX_AVERAGE);
        end
        else
        begin
            need = NEED_W'(cfg.average_count);
        end
        count_inc = NEED_W'(count_reg) + NEED_W'(1);
        complete  = (count_inc >= need);

        num_hi   = SUM_W'(num_reg[NUM_W-1:VOLT_W]);
        overflow = (num_hi >= ref_reg);

        rem_shift = {rem_reg, quot_reg[VOLT_W-1]};
        fits      = (rem_shift >= {1'b0, ref_reg});
        rem_diff  = rem_shift - {1'b0, ref_reg};
        rem_next  = fits ? rem_diff[SUM_W-1:0] : rem_shift[SUM_W-1:0];

        level_map         = map_level(cfg, quot_reg);
        v_plus_margin     = {1'b0, quot_reg} + (VOLT_W+1)'(cfg.hysteresis_margin);
        bound_plus_margin = {1'b0, bound_of(cfg, level_now_reg)}
                          + (VOLT_W+1)'(cfg.hysteresis_margin);
        level_new = level_now_reg;
        if (level_now_reg != level_map)
        begin
            if (level_now_reg > LEVEL_FOUR)
            begin
                level_new = level_map;
            end
            else if (level_now_reg > level_map)
            begin
                if (v_plus_margin < {1'b0, bound_of(cfg, level_map)})
                begin
                    level_new = level_map;
                end
            end
            else if ({1'b0, quot_reg} > bound_plus_margin)
            begin
                level_new = level_map;
            end
        end

        differ      = (level_settled_reg != level_now_reg);
        settle_load = (settle_cnt_reg == '0) ? cfg.settle_count : settle_cnt_reg;
        settle_dec  = (settle_load == '0) ? '0 : settle_load - SETTLE_W'(1);
        commit      = differ && (settle_dec == '0);
    end

    assign stat.avg_complete = complete;
    assign stat.div_skip     = (ref_reg == '0) || overflow;
    assign stat.div_last     = (iter_reg == '1);
    assign stat.out_full     = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsum_reg          <= '0;
            rsum_reg          <= '0;
            count_reg         <= '0;
            iter_reg          <= '0;
            level_now_reg     <= LEVEL_UNKNOWN;
            level_settled_reg <= LEVEL_UNKNOWN;
            settle_cnt_reg    <= '0;
            last_voltage_reg  <= '0;
            done_pend_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                bsum_reg  <= bsum_reg + SUM_W'(battery_sample);
                rsum_reg  <= rsum_reg + SUM_W'(reference_sample);
                count_reg <= complete ? '0 : count_inc[CNT_W-1:0];
            end
            if (cmd.mul)
            begin
                bsum_reg      <= '0;
                rsum_reg      <= '0;
                done_pend_reg <= 1'b1;
            end
            if (cmd.div_init)
            begin
                iter_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                iter_reg <= iter_reg + ITER_W'(1);
            end
            if (cmd.level)
            begin
                level_now_reg    <= level_new;
                last_voltage_reg <= quot_reg;
            end
            if (cmd.load_out)
            begin
                done_pend_reg  <= 1'b0;
                out_valid_reg  <= 1'b1;
                settle_cnt_reg <= differ ? settle_dec : '0;
                if (commit)
                begin
                    level_settled_reg <= level_now_reg;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            num_reg <= {PROD_W'(bsum_reg) * PROD_W'(cfg.vbg_scale), 1'b0};
            ref_reg <= rsum_reg;
        end
        if (cmd.div_init)
        begin
            if (ref_reg == '0)
            begin
                quot_reg <= '0;
            end
            else if (overflow)
            begin
                quot_reg <= TOP_BOUND;
            end
            else
            begin
                rem_reg  <= num_hi;
                quot_reg <= num_reg[VOLT_W-1:0];
            end
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[VOLT_W-2:0], fits};
        end
        if (cmd.load_out)
        begin
            out_measured_reg <= level_now_reg;
            out_stable_reg   <= commit ? level_now_reg : level_settled_reg;
            out_voltage_reg  <= last_voltage_reg;
            out_done_reg     <= done_pend_reg;
            out_changed_reg  <= commit;
            out_poweroff_reg <= commit && (level_now_reg == LEVEL_ZERO);
        end
    end

    assign out_valid         = out_valid_reg;
    assign measured_level    = out_measured_reg;
    assign stable_level      = out_stable_reg;
    assign voltage_mv        = out_voltage_reg;
    assign measurement_done  = out_done_reg;
    assign level_changed     = out_changed_reg;
    assign power_off_request = out_poweroff_reg;

endmodule

// ===== bench/battery_level_monitor_core_test.sv =====
// Self-checking regression of battery_level_monitor_core with a scoreboard and random stimulus.
`timescale 1ns / 100ps

module battery_level_monitor_core_test;
    import blm_pkg::*;

    typedef struct {
        logic [LEVEL_W-1:0] measured;
        logic [LEVEL_W-1:0] stable;
        logic [VOLT_W-1:0]  volt;
        logic               done;
        logic               changed;
        logic               poweroff;
    } level_report_t;

    class battery_level_tracker;
        logic [VBG_W-1:0]    vbg_scale;
        logic [THR_W-1:0]    thr [4];
        logic [MARGIN_W-1:0] margin;
        logic [AVG_W-1:0]    avg_count;
        logic [SETTLE_W-1:0] settle_load;
        int unsigned         battery_sum;
        int unsigned         reference_sum;
        int unsigned         pair_count;
        logic [LEVEL_W-1:0]  level_now;
        logic [LEVEL_W-1:0]  level_settled;
        int unsigned         settle_left;
        logic [VOLT_W-1:0]   last_mv;
        level_report_t       expected_reports [$];
        int unsigned         mismatch_count;

        function new();
            vbg_scale = 10'd800;
            thr[0] = 16'd3400;
            thr[1] = 16'd3500;
            thr[2] = 16'd3700;
            thr[3] = 16'd3850;
            margin = 8'd10;
            avg_count = 5'd10;
            settle_load = 3'd5;
            battery_sum = 0;
            reference_sum = 0;
            pair_count = 0;
            level_now = LEVEL_UNKNOWN;
            level_settled = LEVEL_UNKNOWN;
            settle_left = 0;
            last_mv = '0;
            mismatch_count = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_VBG_SCALE:       vbg_scale = data[VBG_W-1:0];
                REG_THRESHOLD_ZERO:  thr[0] = data;
                REG_THRESHOLD_ONE:   thr[1] = data;
                REG_THRESHOLD_TWO:   thr[2] = data;
                REG_THRESHOLD_THREE: thr[3] = data;
                REG_HYSTERESIS:      margin = data[MARGIN_W-1:0];
                REG_AVERAGE_COUNT:   avg_count = data[AVG_W-1:0];
                REG_SETTLE_COUNT:    settle_load = data[SETTLE_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned upper_bound(logic [LEVEL_W-1:0] lev);
            case (lev)
                LEVEL_ZERO:  return thr[0];
                LEVEL_ONE:   return thr[1];
                LEVEL_TWO:   return thr[2];
                LEVEL_THREE: return thr[3];
                default:     return TOP_BOUND;
            endcase
        endfunction

        function void update_measured_level();
            longint unsigned    quotient;
            int unsigned        mv;
            logic [LEVEL_W-1:0] lev;
            mv = 0;
            if (reference_sum != 0) begin
                quotient = longint'(battery_sum) * longint'(vbg_scale) * 2 / reference_sum;
                mv = (quotient > TOP_BOUND) ? TOP_BOUND : int'(quotient);
            end
            lev = LEVEL_ZERO;
            while (lev < LEVEL_FOUR && mv > upper_bound(lev))
                lev = lev + 1'b1;
            if (level_now != lev) begin
                if (level_now > LEVEL_FOUR)
                    level_now = lev;
                else if (level_now > lev) begin
                    if (mv + margin < upper_bound(lev))
                        level_now = lev;
                end else if (mv > upper_bound(level_now) + margin)
                    level_now = lev;
            end
            last_mv = mv[VOLT_W-1:0];
        endfunction

        function void note_sample(logic [BLM_SAMPLE_BITS-1:0] battery,
                                  logic [BLM_SAMPLE_BITS-1:0] reference);
            int unsigned   need;
            level_report_t rep;
            need = avg_count;
            if (need == 0)
                need = 1;
            if (need > BLM_MAX_AVERAGE)
                need = BLM_MAX_AVERAGE;
            rep.done = 1'b0;
            rep.changed = 1'b0;
            rep.poweroff = 1'b0;
            battery_sum += battery;
            reference_sum += reference;
            pair_count++;
            if (pair_count >= need) begin
                update_measured_level();
                rep.done = 1'b1;
                battery_sum = 0;
                reference_sum = 0;
                pair_count = 0;
            end
            if (level_settled == level_now) begin
                settle_left = 0;
            end else begin
                if (settle_left == 0)
                    settle_left = settle_load;
                if (settle_left > 0)
                    settle_left--;
                if (settle_left == 0) begin
                    level_settled = level_now;
                    rep.changed = 1'b1;
                    rep.poweroff = (level_now == LEVEL_ZERO);
                end
            end
            rep.measured = level_now;
            rep.stable = level_settled;
            rep.volt = last_mv;
            expected_reports.push_back(rep);
        endfunction

        function int unsigned pending();
            return expected_reports.size();
        endfunction

        task flag_mismatch(string msg);
            $display("[%0t] MISMATCH %s", $realtime, msg);
            mismatch_count++;
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                flag_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
        endtask

        task check_report(logic [LEVEL_W-1:0] measured, logic [LEVEL_W-1:0] stable,
                          logic [VOLT_W-1:0] volt, logic done, logic changed,
                          logic poweroff);
            level_report_t want;
            if (expected_reports.size() == 0) begin
                flag_mismatch("result beat with no expected result pending");
            end else begin
                want = expected_reports.pop_front();
                compare_field("measured_level", measured, want.measured);
                compare_field("stable_level", stable, want.stable);
                compare_field("voltage_mv", volt, want.volt);
                compare_field("measurement_done", done, want.done);
                compare_field("level_changed", changed, want.changed);
                compare_field("power_off_request", poweroff, want.poweroff);
            end
        endtask
    endclass

    localparam int unsigned ITEM_GOAL  = 1000;
    localparam int unsigned TAIL_START = 850;
    localparam int unsigned HOLD_CYCLES = 80;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [BLM_SAMPLE_BITS-1:0] battery_sample;
    logic [BLM_SAMPLE_BITS-1:0] reference_sample;
    logic                       out_valid;
    logic                       out_stall;
    logic [LEVEL_W-1:0]         measured_level;
    logic [LEVEL_W-1:0]         stable_level;
    logic [VOLT_W-1:0]          voltage_mv;
    logic                       measurement_done;
    logic                       level_changed;
    logic                       power_off_request;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    battery_level_tracker tracker;
    bit                   idle_on;
    bit                   hold_request;
    int unsigned          items_sent;
    int unsigned          target_mv;
    int unsigned          cur_vbg;
    int unsigned          cur_thr [4];
    int unsigned          cur_margin;
    int unsigned          cur_avg;

    battery_level_monitor_core uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .battery_sample    (battery_sample),
        .reference_sample  (reference_sample),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .measured_level    (measured_level),
        .stable_level      (stable_level),
        .voltage_mv        (voltage_mv),
        .measurement_done  (measurement_done),
        .level_changed     (level_changed),
        .power_off_request (power_off_request),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("battery_level_monitor_core regression: fail");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        tracker.set_reg(idx, val[CFG_DATA_W-1:0]);
        @(negedge clk);
    endtask

    task automatic write_all(input int unsigned vbg, input int unsigned t0, input int unsigned t1,
                             input int unsigned t2, input int unsigned t3,
                             input int unsigned margin, input int unsigned avg,
                             input int unsigned settle);
        write_reg(REG_VBG_SCALE, vbg);
        write_reg(REG_THRESHOLD_ZERO, t0);
        write_reg(REG_THRESHOLD_ONE, t1);
        write_reg(REG_THRESHOLD_TWO, t2);
        write_reg(REG_THRESHOLD_THREE, t3);
        write_reg(REG_HYSTERESIS, margin);
        write_reg(REG_AVERAGE_COUNT, avg);
        write_reg(REG_SETTLE_COUNT, settle);
        cfg_valid = 1'b0;
        cur_vbg = vbg;
        cur_thr[0] = t0;
        cur_thr[1] = t1;
        cur_thr[2] = t2;
        cur_thr[3] = t3;
        cur_margin = margin;
        cur_avg = (avg == 0) ? 1 : ((avg > BLM_MAX_AVERAGE) ? BLM_MAX_AVERAGE : avg);
        target_mv = t1;
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic send_item(input int unsigned battery, input int unsigned reference);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid = 1'b1;
        battery_sample = battery[BLM_SAMPLE_BITS-1:0];
        reference_sample = reference[BLM_SAMPLE_BITS-1:0];
        do @(posedge clk); while (in_stall);
        tracker.note_sample(battery_sample, reference_sample);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_shaped_item();
        int          span;
        int          t;
        int unsigned r;
        int unsigned b;
        if (cur_vbg == 0 || $urandom_range(0, 6) == 0) begin
            send_item($urandom_range(0, 1023), $urandom_range(0, 1023));
        end else begin
            if ($urandom_range(0, 2 * cur_avg) == 0) begin
                span = int'(cur_margin) + 30;
                t = int'(cur_thr[$urandom_range(0, 3)]) + int'($urandom_range(0, 2 * span)) - span;
                target_mv = (t < 0) ? 0 : ((t > 65535) ? 65535 : t);
            end
            r = $urandom_range(200, 1023);
            b = target_mv * r / (2 * cur_vbg);
            send_item((b > 1023) ? 1023 : b, r);
        end
    endtask

    task automatic random_config();
        int unsigned vbg;
        int unsigned t [4];
        int unsigned margin;
        int unsigned avg;
        int unsigned mode;
        mode = $urandom_range(0, 9);
        vbg = (mode == 0) ? 1023 : ((mode == 1) ? $urandom_range(0, 1023) : $urandom_range(500, 1000));
        mode = $urandom_range(0, 9);
        if (mode < 7) begin
            t[0] = $urandom_range(1000, 6000);
            for (int i = 1; i < 4; i++)
                t[i] = t[i-1] + $urandom_range(0, 600);
        end else if (mode == 7) begin
            for (int i = 0; i < 4; i++)
                t[i] = $urandom_range(0, 65535);
        end else if (mode == 8) begin
            for (int i = 0; i < 4; i++)
                t[i] = 65535;
        end else begin
            for (int i = 0; i < 4; i++)
                t[i] = $urandom_range(0, 200) * i;
        end
        margin = ($urandom_range(0, 3) == 0) ? 255 * $urandom_range(0, 1) : $urandom_range(0, 60);
        mode = $urandom_range(0, 9);
        avg = (mode == 0) ? 0 : ((mode == 1) ? $urandom_range(17, 31) : $urandom_range(1, 16));
        write_all(vbg, t[0], t[1], t[2], t[3], margin, avg, $urandom_range(0, 7));
    endtask

    initial
    begin : result_sink
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else if (stall_left != 0) begin
                out_stall = 1'b1;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_stall = 1'b1;
                stall_left = $urandom_range(0, 4);
            end else begin
                out_stall = 1'b0;
            end
            @(posedge clk);
            if (out_valid && !out_stall)
                tracker.check_report(measured_level, stable_level, voltage_mv,
                                     measurement_done, level_changed, power_off_request);
        end
    end

    initial
    begin : stimulus
        int unsigned phase;
        int unsigned count;
        tracker = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        battery_sample = '0;
        reference_sample = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_on = 1'b1;
        hold_request = 1'b0;
        items_sent = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Every beat measures and settles at once; then walk across the first bound
        // with and without enough margin.
        write_all(800, 3400, 3500, 3700, 3850, 10, 0, 0);
        send_item(0, 0);
        send_item(1023, 1);
        send_item(1023, 1023);
        send_item(0, 1023);
        send_item(1023, 0);
        send_item(847, 400);
        send_item(851, 400);
        send_item(853, 400);
        send_item(848, 400);
        send_item(847, 400);
        send_item(682, 341);
        send_item(341, 682);
        send_item(1023, 512);
        send_item(1, 1023);

        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            wait_idle();
            if (phase == 0)
                write_all(1023, 65535, 65535, 65535, 65535, 255, 31, 7);
            else if (phase == 1)
                write_all(0, 0, 0, 0, 0, 0, 1, 0);
            else
                random_config();
            idle_on = ($urandom_range(0, 4) != 0);
            if (phase == 3)
                hold_request = 1'b1;
            count = (phase == 1) ? 30 : $urandom_range(40, 120);
            repeat (count) begin
                if (items_sent >= TAIL_START)
                    idle_on = 1'b0;
                send_shaped_item();
            end
            phase++;
        end
        in_valid = 1'b0;

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (tracker.pending() != 0)
            tracker.flag_mismatch("expected results left over at the end");
        if (tracker.mismatch_count == 0)
            $display("battery_level_monitor_core regression: pass");
        else
            $display("battery_level_monitor_core regression: fail");
        $finish;
    end

endmodule
